FILE: src/round_robin_task_scheduler_macros.svh
// Assertion macros for the round robin task scheduler.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RRTS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/rrts_pkg.sv
// Types and constants shared by the round robin task scheduler modules.
`timescale 1ns / 1ps
package rrts_pkg;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_YIELD  = 3'd1,
      OP_CREATE = 3'd2,
      OP_SLEEP  = 3'd3,
      OP_EXIT   = 3'd4,
      OP_START  = 3'd5,
      OP_QUERY  = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      TS_READY      = 2'd0,
      TS_RUNNING    = 2'd1,
      TS_BLOCKED    = 2'd2,
      TS_TERMINATED = 2'd3
   } task_state_type;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_NOTASKS = 2'd2;

   typedef struct packed {
      task_state_type st;
      logic [63:0]    wake;
      logic [31:0]    run;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_CREATE,
      S_WAKE_WT,
      S_WAKE_CHK,
      S_DEM_WT,
      S_DEM_CHK,
      S_PICK_WT,
      S_PICK_CHK,
      S_ZERO_WT,
      S_ZERO_CHK,
      S_MOD_WT,
      S_MOD_CHK,
      S_QRY_WT,
      S_QRY_CHK,
      S_DONE
   } fsm_state_type;

   typedef enum logic [2:0] {
      ADDR_HOLD,
      ADDR_ZERO,
      ADDR_RUN,
      ADDR_COUNT,
      ADDR_QIDX,
      ADDR_INC,
      ADDR_PICK_FIRST,
      ADDR_PICK_NEXT
   } addr_op_type;

   typedef enum logic [2:0] {
      WR_CREATE,
      WR_WAKE,
      WR_DEMOTE,
      WR_RUNNING,
      WR_SLEEP,
      WR_EXIT
   } wr_kind_type;

   typedef struct packed {
      logic        latch;
      logic        tick_inc;
      addr_op_type addr_op;
      logic        wr_en;
      wr_kind_type wr_kind;
      logic        dispatch;
      logic        create_done;
      logic        set_full;
      logic        set_notasks;
      logic        q_capture;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type         op;
      logic           active;
      logic           count_ge2;
      logic           count_zero;
      logic           count_one;
      logic           count_full;
      logic           have_cur;
      logic           ticks_nz;
      logic           qidx_in;
      task_state_type st;
      logic           wake_due;
      logic           addr_last;
      logic           scan_last;
      logic           rsp_free;
   } stat_type;

endpackage

FILE: src/rrts_ctrl.sv
// Sequencing state machine of the round robin task scheduler.
`timescale 1ns / 1ps
module rrts_ctrl
   import rrts_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.addr_op = ADDR_HOLD;
      cmd.wr_kind = WR_WAKE;
      req_ready = (state_ff == S_IDLE) && !reset;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.latch = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.op)
               OP_TICK, OP_YIELD: begin
                  cmd.tick_inc = (stat.op == OP_TICK);
                  if (stat.active && stat.count_ge2) begin
                     cmd.addr_op = ADDR_ZERO;
                     state_in = S_WAKE_WT;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               OP_CREATE: begin
                  if (stat.count_full) begin
                     cmd.set_full = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     cmd.addr_op = ADDR_COUNT;
                     state_in = S_CREATE;
                  end
               end
               OP_SLEEP, OP_EXIT: begin
                  if (stat.have_cur && (stat.ticks_nz || stat.op == OP_EXIT)) begin
                     cmd.addr_op = ADDR_RUN;
                     state_in = S_MOD_WT;
                  end else if (stat.active && stat.count_ge2) begin
                     cmd.addr_op = ADDR_ZERO;
                     state_in = S_WAKE_WT;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               OP_START: begin
                  if (stat.count_zero) begin
                     cmd.set_notasks = 1'b1;
                     state_in = S_DONE;
                  end else if (stat.active) begin
                     state_in = S_DONE;
                  end else if (stat.count_one) begin
                     cmd.addr_op = ADDR_ZERO;
                     state_in = S_ZERO_WT;
                  end else begin
                     cmd.addr_op = ADDR_PICK_FIRST;
                     state_in = S_PICK_WT;
                  end
               end
               OP_QUERY: begin
                  if (stat.qidx_in) begin
                     cmd.addr_op = ADDR_QIDX;
                     state_in = S_QRY_WT;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_CREATE: begin
            cmd.wr_en = 1'b1;
            cmd.wr_kind = WR_CREATE;
            cmd.create_done = 1'b1;
            state_in = S_DONE;
         end
         S_WAKE_WT: state_in = S_WAKE_CHK;
         S_WAKE_CHK: begin
            cmd.wr_en = (stat.st == TS_BLOCKED) && stat.wake_due;
            cmd.wr_kind = WR_WAKE;
            if (!stat.addr_last) begin
               cmd.addr_op = ADDR_INC;
               state_in = S_WAKE_WT;
            end else if (stat.have_cur) begin
               cmd.addr_op = ADDR_RUN;
               state_in = S_DEM_WT;
            end else begin
               cmd.addr_op = ADDR_PICK_FIRST;
               state_in = S_PICK_WT;
            end
         end
         S_DEM_WT: state_in = S_DEM_CHK;
         S_DEM_CHK: begin
            cmd.wr_en = (stat.st == TS_RUNNING);
            cmd.wr_kind = WR_DEMOTE;
            cmd.addr_op = ADDR_PICK_FIRST;
            state_in = S_PICK_WT;
         end
         S_PICK_WT: state_in = S_PICK_CHK;
         S_PICK_CHK: begin
            if (stat.st == TS_READY) begin
               cmd.wr_en = 1'b1;
               cmd.wr_kind = WR_RUNNING;
               cmd.dispatch = 1'b1;
               state_in = S_DONE;
            end else if (stat.scan_last) begin
               cmd.addr_op = ADDR_ZERO;
               state_in = S_ZERO_WT;
            end else begin
               cmd.addr_op = ADDR_PICK_NEXT;
               state_in = S_PICK_WT;
            end
         end
         S_ZERO_WT: state_in = S_ZERO_CHK;
         S_ZERO_CHK: begin
            if (stat.st == TS_READY || stat.op == OP_START) begin
               cmd.wr_en = 1'b1;
               cmd.wr_kind = WR_RUNNING;
               cmd.dispatch = 1'b1;
            end
            state_in = S_DONE;
         end
         S_MOD_WT: state_in = S_MOD_CHK;
         S_MOD_CHK: begin
            cmd.wr_en = 1'b1;
            cmd.wr_kind = (stat.op == OP_SLEEP) ? WR_SLEEP : WR_EXIT;
            if (stat.active && stat.count_ge2) begin
               cmd.addr_op = ADDR_ZERO;
               state_in = S_WAKE_WT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_QRY_WT: state_in = S_QRY_CHK;
         S_QRY_CHK: begin
            cmd.q_capture = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: src/rrts_dp.sv
// Datapath of the round robin task scheduler: task table, counters, result register.
`timescale 1ns / 1ps
module rrts_dp
   import rrts_pkg::*;
#(
   parameter int TASK_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_sleep_ticks,
   input  logic [3:0]  req_query_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_current_task,
   output logic        rsp_current_valid,
   output logic        rsp_switched,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_new_task_id,
   output logic [4:0]  rsp_task_count_out,
   output logic [1:0]  rsp_queried_state,
   output logic [31:0] rsp_queried_run_ticks,
   output logic [63:0] rsp_tick_now
);

   localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W = $clog2(TASK_SLOTS + 1);
   localparam logic [7:0] SLOTS8 = 8'(TASK_SLOTS);

   entry_type mem [TASK_SLOTS];
   entry_type rdata_ff;
   entry_type wdata;

   op_type             op_ff;
   logic [31:0]        ticks_ff;
   logic [3:0]         qidx_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [IDX_W-1:0]   run_idx_ff;
   logic               run_valid_ff;
   logic               active_ff;
   logic [63:0]        gt_ff;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               switched_ff;
   logic [1:0]         status_ff;
   logic [3:0]         new_id_ff;
   logic [1:0]         q_state_ff;
   logic [31:0]        q_ticks_ff;

   logic               rsp_valid_ff;
   logic [3:0]         rsp_task_ff;
   logic               rsp_cvalid_ff;
   logic               rsp_switched_ff;
   logic [1:0]         rsp_status_ff;
   logic [3:0]         rsp_new_id_ff;
   logic [4:0]         rsp_count_ff;
   logic [1:0]         rsp_qstate_ff;
   logic [31:0]        rsp_qticks_ff;
   logic [63:0]        rsp_tick_ff;

   logic [7:0]  count8;
   logic [7:0]  run8;
   logic [7:0]  addr8;
   logic [7:0]  base8;
   logic        have_cur;
   logic [64:0] wake_sum;
   logic [63:0] wake_new;

   assign count8   = 8'(count_ff);
   assign run8     = 8'(run_idx_ff);
   assign addr8    = 8'(addr_ff);
   assign have_cur = run_valid_ff && (run8 < count8);
   assign base8    = (op_ff != OP_START && have_cur) ? run8 : 8'd0;
   assign wake_sum = {1'b0, gt_ff} + {33'd0, ticks_ff};
   assign wake_new = wake_sum[64] ? '1 : wake_sum[63:0];

   always_comb begin
      stat.op         = op_ff;
      stat.active     = active_ff;
      stat.count_ge2  = (count8 >= 8'd2);
      stat.count_zero = (count8 == 8'd0);
      stat.count_one  = (count8 == 8'd1);
      stat.count_full = (count8 >= SLOTS8);
      stat.have_cur   = have_cur;
      stat.ticks_nz   = (ticks_ff != 32'd0);
      stat.qidx_in    = (8'(qidx_ff) < count8);
      stat.st         = rdata_ff.st;
      stat.wake_due   = (rdata_ff.wake <= gt_ff);
      stat.addr_last  = (addr8 + 8'd1 == count8);
      stat.scan_last  = (scan_ff == CNT_W'(1));
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      addr_in = addr_ff;
      scan_in = scan_ff;
      unique case (cmd.addr_op)
         ADDR_HOLD:  addr_in = addr_ff;
         ADDR_ZERO:  addr_in = '0;
         ADDR_RUN:   addr_in = run_idx_ff;
         ADDR_COUNT: addr_in = IDX_W'(count_ff);
         ADDR_QIDX:  addr_in = IDX_W'(qidx_ff);
         ADDR_INC:   addr_in = IDX_W'(addr8 + 8'd1);
         ADDR_PICK_FIRST: begin
            addr_in = (base8 + 8'd1 >= count8) ? IDX_W'(1) : IDX_W'(base8 + 8'd1);
            scan_in = CNT_W'(count8 - 8'd1);
         end
         ADDR_PICK_NEXT: begin
            addr_in = (addr8 + 8'd1 >= count8) ? IDX_W'(1) : IDX_W'(addr8 + 8'd1);
            scan_in = scan_ff - CNT_W'(1);
         end
         default: addr_in = addr_ff;
      endcase
   end

   always_comb begin
      wdata = rdata_ff;
      unique case (cmd.wr_kind)
         WR_CREATE: begin
            wdata.st   = TS_READY;
            wdata.wake = '0;
            wdata.run  = '0;
         end
         WR_WAKE: wdata.st = TS_READY;
         WR_DEMOTE: begin
            wdata.st = TS_READY;
            if (op_ff == OP_TICK && rdata_ff.run != '1) begin
               wdata.run = rdata_ff.run + 32'd1;
            end
         end
         WR_RUNNING: wdata.st = TS_RUNNING;
         WR_SLEEP: begin
            wdata.st   = TS_BLOCKED;
            wdata.wake = wake_new;
         end
         WR_EXIT: wdata.st = TS_TERMINATED;
         default: wdata = rdata_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[addr_ff] <= wdata;
      end
      rdata_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      scan_ff <= scan_in;
      if (cmd.latch) begin
         op_ff    <= op_type'(req_op);
         ticks_ff <= req_sleep_ticks;
         qidx_ff  <= req_query_index;
      end
      if (cmd.q_capture) begin
         q_state_ff <= rdata_ff.st;
         q_ticks_ff <= rdata_ff.run;
      end else if (cmd.latch) begin
         q_state_ff <= '0;
         q_ticks_ff <= '0;
      end
      if (cmd.create_done) begin
         new_id_ff <= 4'(count_ff);
      end else if (cmd.latch) begin
         new_id_ff <= '0;
      end
      if (cmd.rsp_load) begin
         rsp_task_ff     <= 4'(run_idx_ff);
         rsp_cvalid_ff   <= run_valid_ff;
         rsp_switched_ff <= switched_ff;
         rsp_status_ff   <= status_ff;
         rsp_new_id_ff   <= new_id_ff;
         rsp_count_ff    <= 5'(count_ff);
         rsp_qstate_ff   <= q_state_ff;
         rsp_qticks_ff   <= q_ticks_ff;
         rsp_tick_ff     <= gt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         run_idx_ff   <= '0;
         run_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         gt_ff        <= '0;
         switched_ff  <= 1'b0;
         status_ff    <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.latch) begin
            switched_ff <= 1'b0;
            status_ff   <= STATUS_OK;
         end
         if (cmd.tick_inc) begin
            gt_ff <= gt_ff + 64'd1;
         end
         if (cmd.create_done) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.set_full) begin
            status_ff <= STATUS_FULL;
         end
         if (cmd.set_notasks) begin
            status_ff <= STATUS_NOTASKS;
         end
         if (cmd.dispatch) begin
            run_idx_ff   <= addr_ff;
            run_valid_ff <= 1'b1;
            switched_ff  <= 1'b1;
            if (op_ff == OP_START) begin
               active_ff <= 1'b1;
            end
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_current_task      = rsp_task_ff;
   assign rsp_current_valid     = rsp_cvalid_ff;
   assign rsp_switched          = rsp_switched_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_new_task_id       = rsp_new_id_ff;
   assign rsp_task_count_out    = rsp_count_ff;
   assign rsp_queried_state     = rsp_qstate_ff;
   assign rsp_queried_run_ticks = rsp_qticks_ff;
   assign rsp_tick_now          = rsp_tick_ff;

endmodule

FILE: src/round_robin_task_scheduler.sv
// Sequence: S_IDLE latches the request and S_DISPATCH decodes it; create writes its slot in
// S_CREATE, a one-slot op reads in a _WT state and acts in _CHK, and a sleep or exit that
// reschedules adds a wake sweep and round-robin scan, slot by slot, one port.
// Throughput: one transaction in flight; the next is accepted the cycle after the result
// register loads, and a stalled result holds the controller in its last state.
// Reset: synchronous; clears counters, tick count and state; the task table is not cleared.
`timescale 1ns / 1ps
`include "round_robin_task_scheduler_macros.svh"
module round_robin_task_scheduler
   import rrts_pkg::*;
#(
   parameter int TASK_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_sleep_ticks,
   input  logic [3:0]  req_query_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_current_task,
   output logic        rsp_current_valid,
   output logic        rsp_switched,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_new_task_id,
   output logic [4:0]  rsp_task_count_out,
   output logic [1:0]  rsp_queried_state,
   output logic [31:0] rsp_queried_run_ticks,
   output logic [63:0] rsp_tick_now
);

   cmd_type  cmd;
   stat_type stat;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rrts_dp #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_op                (req_op),
      .req_sleep_ticks       (req_sleep_ticks),
      .req_query_index       (req_query_index),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_current_task      (rsp_current_task),
      .rsp_current_valid     (rsp_current_valid),
      .rsp_switched          (rsp_switched),
      .rsp_status            (rsp_status),
      .rsp_new_task_id       (rsp_new_task_id),
      .rsp_task_count_out    (rsp_task_count_out),
      .rsp_queried_state     (rsp_queried_state),
      .rsp_queried_run_ticks (rsp_queried_run_ticks),
      .rsp_tick_now          (rsp_tick_now)
   );

   `RRTS_ASSERT_IMPLY(a_switch_has_task, clock, reset,
      rsp_valid && rsp_switched, rsp_current_valid, "switch without current task")
   `RRTS_ASSERT_IMPLY(a_error_no_switch, clock, reset,
      rsp_valid && rsp_status != STATUS_OK, !rsp_switched, "switch reported with error status")
   `RRTS_ASSERT_NEXT(a_busy_after_accept, clock, reset,
      req_valid && req_ready, !req_ready, "ready held after accepted transaction")

endmodule
